// ----- rtl/im2col_pkg.sv -----
// shared types for the im2col patch unroller
`default_nettype none
package im2col_pkg;

	typedef struct packed {
		logic [4:0] ch;
		logic [6:0] h;
		logic [6:0] w;
		logic [3:0] k;
		logic [3:0] s;
		logic [3:0] p;
		logic [7:0] zr;
		logic [7:0] zc;
		logic       has_patches;
	} cfg_t;

	typedef struct packed {
		logic        produce;
		logic [3:0]  chan;
		logic [5:0]  row;
		logic [5:0]  col;
		logic        in_image;
		logic        last;
		logic [23:0] index;
	} walk_t;

endpackage
`default_nettype wire

// ----- rtl/im2col_patch_unroller_unit.sv -----
// im2col patch unroller top level: image store, address pipeline, stream ports
// an accepted emit passes stages 1, 2 and 3 and the stage 4 output register before m_tvalid shows it
// throughput: one transaction per cycle while m_tready does not stall the pipeline, set by the single-port image store
// stores and emits share the store port in order, so an emit sees every earlier store
// reset: config registers go to their reset values, walk counters clear, pipeline empties
// the image store is not cleared and holds undefined words until written
`default_nettype none
module im2col_patch_unroller_unit import im2col_pkg::*; #(
	parameter int IMAGE_WORDS = 65536,
	parameter int DATA_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // load_address[15:0], load_value[47:16]
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // element_value[31:0], matrix_index[55:32]
	output logic        m_tuser,   // is_zero_fill
	output logic        m_tlast
);

	localparam int AW = $clog2(IMAGE_WORDS);
	localparam int XW = (AW > 16) ? AW + 1 : 17;
	localparam int MW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	cfg_t  cfg;
	walk_t cur;
	logic  restart;
	logic  accept;

	// stage valids and handshake
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1
	logic          st_s1;
	logic [15:0]   ld_addr_s1;
	logic [MW-1:0] ld_val_s1;
	logic [3:0]    chan_s1;
	logic [5:0]    row_s1, col_s1;
	logic          inside_s1, last_s1;
	logic [23:0]   idx_s1;

	// stage 2
	logic          st_s2;
	logic [15:0]   ld_addr_s2;
	logic [MW-1:0] ld_val_s2;
	logic [9:0]    t_s2;
	logic [5:0]    col_s2;
	logic          inside_s2, last_s2;
	logic [23:0]   idx_s2;

	// stage 3
	logic          st_s3;
	logic [XW-1:0] addr_s3;
	logic          in_range_s3;
	logic [MW-1:0] ld_val_s3;
	logic          inside_s3, last_s3;
	logic [23:0]   idx_s3;

	// stage 4, the output register
	logic [MW-1:0] rd_s4;
	logic          keep_s4, zero_s4, last_s4;
	logic [23:0]   idx_s4;

	logic [XW-1:0] addr_nx;
	logic [15:0]   emit_addr;

	logic [MW-1:0] mem [IMAGE_WORDS];

	assign pready = 1'b1;

	im2col_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.restart (restart),
		.cfg     (cfg)
	);

	im2col_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.step    (accept && s_tuser),
		.cur     (cur)
	);

	assign rdy4     = !v4_q || m_tready;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= accept && (!s_tuser || cur.produce);
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q && !st_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			st_s1      <= !s_tuser;
			ld_addr_s1 <= s_tdata[15:0];
			ld_val_s1  <= s_tdata[16 +: MW];
			chan_s1    <= cur.chan;
			row_s1     <= cur.row;
			col_s1     <= cur.col;
			inside_s1  <= cur.in_image;
			last_s1    <= cur.last;
			idx_s1     <= cur.index;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			st_s2      <= st_s1;
			ld_addr_s2 <= ld_addr_s1;
			ld_val_s2  <= ld_val_s1;
			t_s2       <= 10'(chan_s1) * 10'(cfg.h) + 10'(row_s1);
			col_s2     <= col_s1;
			inside_s2  <= inside_s1;
			last_s2    <= last_s1;
			idx_s2     <= idx_s1;
		end
	end

	assign emit_addr = 16'(t_s2) * 16'(cfg.w) + 16'(col_s2);
	assign addr_nx   = st_s2 ? XW'(ld_addr_s2) : XW'(emit_addr);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			st_s3       <= st_s2;
			addr_s3     <= addr_nx;
			in_range_s3 <= addr_nx < XW'(IMAGE_WORDS);
			ld_val_s3   <= ld_val_s2;
			inside_s3   <= inside_s2;
			last_s3     <= last_s2;
			idx_s3      <= idx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v3_q && in_range_s3) begin
			if (st_s3) mem[addr_s3[AW-1:0]] <= ld_val_s3;
			else       rd_s4 <= mem[addr_s3[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			keep_s4 <= inside_s3 && in_range_s3;
			zero_s4 <= !inside_s3;
			last_s4 <= last_s3;
			idx_s4  <= idx_s3;
		end
	end

	assign m_tvalid = v4_q;
	assign m_tdata  = {idx_s4, (keep_s4 ? 32'(rd_s4) : 32'd0)};
	assign m_tuser  = zero_s4;
	assign m_tlast  = last_s4;

endmodule
`default_nettype wire

// ----- rtl/im2col_cfg.sv -----
// configuration registers with apb access and range saturation
`default_nettype none
module im2col_cfg import im2col_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        restart,
	output cfg_t        cfg
);

	localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd2;
	localparam logic [2:0] REG_KERNEL_SIZE     = 3'd3;
	localparam logic [2:0] REG_STEP_SIZE       = 3'd4;
	localparam logic [2:0] REG_BORDER_PAD      = 3'd5;
	localparam logic [2:0] REG_EXTRA_ZERO_ROWS = 3'd6;
	localparam logic [2:0] REG_EXTRA_ZERO_COLS = 3'd7;

	logic [4:0] ch_q;
	logic [6:0] h_q;
	logic [6:0] w_q;
	logic [3:0] k_q;
	logic [3:0] s_q;
	logic [3:0] p_q;
	logic [7:0] zr_q;
	logic [7:0] zc_q;
	logic [2:0] sel;
	logic [7:0] hp2;
	logic [7:0] wp2;

	assign sel     = paddr[4:2];
	assign restart = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= 5'd1;
			h_q  <= 7'd1;
			w_q  <= 7'd1;
			k_q  <= 4'd1;
			s_q  <= 4'd1;
			p_q  <= 4'd0;
			zr_q <= 8'd0;
			zc_q <= 8'd0;
		end else if (restart) begin
			unique case (sel)
				REG_CHANNEL_COUNT:   ch_q <= pwdata[4:0];
				REG_IMAGE_HEIGHT:    h_q  <= pwdata[6:0];
				REG_IMAGE_WIDTH:     w_q  <= pwdata[6:0];
				REG_KERNEL_SIZE:     k_q  <= pwdata[3:0];
				REG_STEP_SIZE:       s_q  <= pwdata[3:0];
				REG_BORDER_PAD:      p_q  <= pwdata[3:0];
				REG_EXTRA_ZERO_ROWS: zr_q <= pwdata[7:0];
				REG_EXTRA_ZERO_COLS: zc_q <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_CHANNEL_COUNT:   prdata = 32'(ch_q);
			REG_IMAGE_HEIGHT:    prdata = 32'(h_q);
			REG_IMAGE_WIDTH:     prdata = 32'(w_q);
			REG_KERNEL_SIZE:     prdata = 32'(k_q);
			REG_STEP_SIZE:       prdata = 32'(s_q);
			REG_BORDER_PAD:      prdata = 32'(p_q);
			REG_EXTRA_ZERO_ROWS: prdata = 32'(zr_q);
			REG_EXTRA_ZERO_COLS: prdata = 32'(zc_q);
		endcase
	end

	// saturate into the legal ranges
	always_comb begin
		cfg.ch = (ch_q == 5'd0) ? 5'd1 : ((ch_q > 5'd16) ? 5'd16 : ch_q);
		cfg.h  = (h_q == 7'd0) ? 7'd1 : ((h_q > 7'd64) ? 7'd64 : h_q);
		cfg.w  = (w_q == 7'd0) ? 7'd1 : ((w_q > 7'd64) ? 7'd64 : w_q);
		cfg.k  = (k_q == 4'd0) ? 4'd1 : ((k_q > 4'd11) ? 4'd11 : k_q);
		cfg.s  = (s_q == 4'd0) ? 4'd1 : ((s_q > 4'd8) ? 4'd8 : s_q);
		cfg.p  = (p_q > 4'd8) ? 4'd8 : p_q;
		cfg.zr = zr_q;
		cfg.zc = zc_q;
		hp2 = 8'(cfg.h) + {3'd0, cfg.p, 1'b0};
		wp2 = 8'(cfg.w) + {3'd0, cfg.p, 1'b0};
		cfg.has_patches = (8'(cfg.k) <= hp2) && (8'(cfg.k) <= wp2);
	end

endmodule
`default_nettype wire

// ----- rtl/im2col_walk.sv -----
// nested window and kernel counters that walk the unrolled matrix
`default_nettype none
module im2col_walk import im2col_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  restart,
	input  logic  step,
	output walk_t cur
);

	localparam logic [1:0] PH_PATCH = 2'd0;
	localparam logic [1:0] PH_COLS  = 2'd1;
	localparam logic [1:0] PH_ROWS  = 2'd2;
	localparam logic [1:0] PH_RCOLS = 2'd3;

	logic [1:0]  phase_q, phase_n, eff_phase;
	logic [6:0]  wr_q, wr_n, wc_q, wc_n;
	logic [3:0]  ch_q, ch_n, kr_q, kr_n, kc_q, kc_n;
	logic [7:0]  fill_q, fill_n, zrow_q, zrow_n;
	logic [23:0] elem_q, elem_n;

	logic [7:0] fr, fc, pad, wc_nx, wr_nx;
	logic [8:0] hp2, wp2;
	logic       kc_end, kr_end, ch_end, fill_end, zrow_end;
	logic       col_over, row_over;
	logic       content_end, go_window, go_rowend, last;

	assign eff_phase = (phase_q == PH_PATCH && !cfg.has_patches) ? PH_ROWS : phase_q;

	assign pad = {4'd0, cfg.p};
	assign fr  = {1'b0, wr_q} + {4'd0, kr_q};
	assign fc  = {1'b0, wc_q} + {4'd0, kc_q};
	assign hp2 = 9'(cfg.h) + {4'd0, cfg.p, 1'b0};
	assign wp2 = 9'(cfg.w) + {4'd0, cfg.p, 1'b0};

	assign kc_end   = (5'(kc_q) + 5'd1) >= 5'(cfg.k);
	assign kr_end   = (5'(kr_q) + 5'd1) >= 5'(cfg.k);
	assign ch_end   = (5'(ch_q) + 5'd1) >= cfg.ch;
	assign fill_end = (9'(fill_q) + 9'd1) >= 9'(cfg.zc);
	assign zrow_end = (9'(zrow_q) + 9'd1) >= 9'(cfg.zr);

	assign wc_nx    = {1'b0, wc_q} + {4'd0, cfg.s};
	assign wr_nx    = {1'b0, wr_q} + {4'd0, cfg.s};
	assign col_over = (9'(wc_nx) + 9'(cfg.k)) > wp2;
	assign row_over = (9'(wr_nx) + 9'(cfg.k)) > hp2;

	assign content_end = kc_end && kr_end && ch_end;

	always_comb begin
		go_window = 1'b0;
		go_rowend = 1'b0;
		unique case (eff_phase)
			PH_PATCH: go_window = content_end && (cfg.zc == 8'd0);
			PH_COLS:  go_window = fill_end;
			PH_ROWS:  go_rowend = content_end && (cfg.zc == 8'd0);
			PH_RCOLS: go_rowend = fill_end;
		endcase
		last = (go_window && col_over && row_over && cfg.zr == 8'd0) ||
			(go_rowend && zrow_end);
	end

	always_comb begin
		cur.produce  = cfg.has_patches || (cfg.zr != 8'd0);
		cur.chan     = ch_q;
		cur.row      = 6'(fr - pad);
		cur.col      = 6'(fc - pad);
		cur.in_image = (eff_phase == PH_PATCH) && (fr >= pad) && (fr < pad + 8'(cfg.h)) &&
			(fc >= pad) && (fc < pad + 8'(cfg.w));
		cur.last     = last;
		cur.index    = elem_q;
	end

	always_comb begin
		phase_n = phase_q;
		wr_n    = wr_q;
		wc_n    = wc_q;
		ch_n    = ch_q;
		kr_n    = kr_q;
		kc_n    = kc_q;
		fill_n  = fill_q;
		zrow_n  = zrow_q;
		elem_n  = elem_q;
		if (step && cur.produce) begin
			elem_n = elem_q + 24'd1;
			unique case (eff_phase)
				PH_PATCH, PH_ROWS: begin
					kc_n = kc_q + 4'd1;
					if (kc_end) begin
						kc_n = 4'd0;
						kr_n = kr_q + 4'd1;
						if (kr_end) begin
							kr_n = 4'd0;
							ch_n = ch_q + 4'd1;
							if (ch_end) begin
								ch_n = 4'd0;
								if (cfg.zc != 8'd0) begin
									phase_n = (eff_phase == PH_PATCH) ? PH_COLS : PH_RCOLS;
									fill_n  = 8'd0;
								end else begin
									phase_n = eff_phase;
								end
							end
						end
					end
				end
				PH_COLS, PH_RCOLS: fill_n = fill_q + 8'd1;
			endcase
			if (go_window) begin
				phase_n = PH_PATCH;
				wc_n    = wc_nx[6:0];
				if (col_over) begin
					wc_n = 7'd0;
					wr_n = wr_nx[6:0];
					if (row_over) begin
						wr_n    = 7'd0;
						phase_n = PH_ROWS;
						fill_n  = 8'd0;
						zrow_n  = 8'd0;
					end
				end
			end
			if (go_rowend) begin
				phase_n = PH_ROWS;
				zrow_n  = zrow_q + 8'd1;
			end
			if (last) begin
				phase_n = PH_PATCH;
				wr_n    = 7'd0;
				wc_n    = 7'd0;
				ch_n    = 4'd0;
				kr_n    = 4'd0;
				kc_n    = 4'd0;
				fill_n  = 8'd0;
				zrow_n  = 8'd0;
				elem_n  = 24'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PATCH;
			wr_q    <= 7'd0;
			wc_q    <= 7'd0;
			ch_q    <= 4'd0;
			kr_q    <= 4'd0;
			kc_q    <= 4'd0;
			fill_q  <= 8'd0;
			zrow_q  <= 8'd0;
			elem_q  <= 24'd0;
		end else if (restart) begin
			phase_q <= PH_PATCH;
			wr_q    <= 7'd0;
			wc_q    <= 7'd0;
			ch_q    <= 4'd0;
			kr_q    <= 4'd0;
			kc_q    <= 4'd0;
			fill_q  <= 8'd0;
			zrow_q  <= 8'd0;
			elem_q  <= 24'd0;
		end else begin
			phase_q <= phase_n;
			wr_q    <= wr_n;
			wc_q    <= wc_n;
			ch_q    <= ch_n;
			kr_q    <= kr_n;
			kc_q    <= kc_n;
			fill_q  <= fill_n;
			zrow_q  <= zrow_n;
			elem_q  <= elem_n;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/im2col_checker.sv -----
// port-level checks for the im2col patch unroller, bound to the top level
`default_nettype none
module im2col_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic [23:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= 24'd0;
		end else if (psel && penable && pwrite) begin
			exp_idx_q <= 24'd0;
		end else if (m_tvalid && m_tready) begin
			exp_idx_q <= m_tlast ? 24'd0 : m_tdata[55:32] + 24'd1;
		end
	end

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// fill elements carry zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("zero fill element has nonzero value");

	// matrix index runs in order and restarts after last or after an apb write
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> m_tdata[55:32] == exp_idx_q)
		else $error("matrix index out of sequence");

endmodule

bind im2col_patch_unroller_unit im2col_checker u_im2col_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
